// ----- rtl/wsfd_pkg.sv -----
`default_nettype none

package wsfd_pkg;

    // Parse phases.
    localparam logic [2:0] PH_HDR0    = 3'd0;
    localparam logic [2:0] PH_HDR1    = 3'd1;
    localparam logic [2:0] PH_EXT     = 3'd2;
    localparam logic [2:0] PH_KEY     = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;

    // Second-byte rules of a multi-byte UTF-8 sequence.
    localparam logic [2:0] RULE_NONE = 3'd0;
    localparam logic [2:0] RULE_E0   = 3'd1;
    localparam logic [2:0] RULE_ED   = 3'd2;
    localparam logic [2:0] RULE_F0   = 3'd3;
    localparam logic [2:0] RULE_F4   = 3'd4;

    // Opcodes of interest.
    localparam logic [3:0] OP_CONT  = 4'd0;
    localparam logic [3:0] OP_TEXT  = 4'd1;
    localparam logic [3:0] OP_CLOSE = 4'd8;

    // Frame status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_CTRL = 2'd1;
    localparam logic [1:0] ST_UTF8 = 2'd2;

    // Length field escapes.
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    typedef struct packed {
        logic [1:0] pending;
        logic [2:0] rule;
        logic       bad;
    } t_utf8;

    typedef struct packed {
        logic       valid;
        logic       has_byte;
        logic [7:0] data_byte;
        logic [3:0] msg_opcode;
        logic       was_masked;
        logic       frame_end;
        logic       message_end;
        logic [1:0] frame_status;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/wsfd_utf8.sv -----
`default_nettype none

module wsfd_utf8 (
    input  wsfd_pkg::t_utf8 i_state,
    input  logic [7:0]      i_byte,
    output wsfd_pkg::t_utf8 o_state
);
    import wsfd_pkg::*;

    always_comb begin
        o_state = i_state;
        if (i_state.pending != 2'd0) begin
            if (i_byte[7:6] != 2'b10) begin
                o_state.bad     = 1'b1;
                o_state.pending = 2'd0;
                o_state.rule    = RULE_NONE;
            end else begin
                unique case (i_state.rule)
                    RULE_E0: if (i_byte[7:5] == 3'b100) o_state.bad = 1'b1;
                    RULE_ED: if (i_byte[7:5] == 3'b101) o_state.bad = 1'b1;
                    RULE_F0: if (i_byte[7:4] == 4'b1000) o_state.bad = 1'b1;
                    RULE_F4: if (i_byte > 8'h8F) o_state.bad = 1'b1;
                    default: ;
                endcase
                o_state.rule    = RULE_NONE;
                o_state.pending = i_state.pending - 2'd1;
            end
        end else if (i_byte[7]) begin
            // Leads C0 and C1 are taken as two-byte leads.
            if (i_byte[7:5] == 3'b110) begin
                o_state.pending = 2'd1;
            end else if (i_byte[7:4] == 4'b1110) begin
                o_state.pending = 2'd2;
                o_state.rule    = (i_byte == 8'hE0) ? RULE_E0 :
                                  (i_byte == 8'hED) ? RULE_ED : RULE_NONE;
            end else if (i_byte[7:3] == 5'b11110) begin
                if (i_byte > 8'hF4) o_state.bad = 1'b1;
                o_state.pending = 2'd3;
                o_state.rule    = (i_byte == 8'hF0) ? RULE_F0 :
                                  (i_byte == 8'hF4) ? RULE_F4 : RULE_NONE;
            end else begin
                o_state.bad = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/wsfd_parser.sv -----
`default_nettype none

module wsfd_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    output wsfd_pkg::t_result o_result
);
    import wsfd_pkg::*;

    logic [2:0]  r_phase,     n_phase;
    logic [3:0]  r_hidx,      n_hidx;
    logic        r_fin,       n_fin;
    logic [3:0]  r_opcode,    n_opcode;
    logic        r_masked,    n_masked;
    logic [63:0] r_left,      n_left;
    logic [31:0] r_key,       n_key;
    logic [1:0]  r_kidx,      n_kidx;
    logic [3:0]  r_frag,      n_frag;
    t_utf8       r_utf,       n_utf;
    logic        r_skip,      n_skip;
    logic        r_closed,    n_closed;

    t_utf8       w_utf_fed;
    logic [7:0]  w_key_byte;
    logic [7:0]  w_data;
    logic [6:0]  w_len7;
    logic        w_emit;
    logic        w_end;
    logic        w_has;

    assign w_len7 = i_byte[6:0];

    always_comb begin
        unique case (r_kidx)
            2'd0:    w_key_byte = r_key[31:24];
            2'd1:    w_key_byte = r_key[23:16];
            2'd2:    w_key_byte = r_key[15:8];
            default: w_key_byte = r_key[7:0];
        endcase
    end

    assign w_data = i_byte ^ w_key_byte;

    wsfd_utf8 u_utf8 (
        .i_state (r_utf),
        .i_byte  (w_data),
        .o_state (w_utf_fed)
    );

    always_comb begin
        n_phase  = r_phase;
        n_hidx   = r_hidx;
        n_fin    = r_fin;
        n_opcode = r_opcode;
        n_masked = r_masked;
        n_left   = r_left;
        n_key    = r_key;
        n_kidx   = r_kidx;
        n_frag   = r_frag;
        n_utf    = r_utf;
        n_skip   = r_skip;
        n_closed = r_closed;
        w_emit   = 1'b0;
        w_end    = 1'b0;
        w_has    = 1'b0;

        if (!r_closed) begin
            unique case (r_phase)
                PH_HDR0: begin
                    n_fin    = i_byte[7];
                    n_opcode = i_byte[3:0];
                    n_masked = 1'b0;
                    n_left   = '0;
                    n_key    = '0;
                    n_kidx   = 2'd0;
                    n_utf    = '{pending: 2'd0, rule: RULE_NONE, bad: 1'b0};
                    // Control opcodes have the top opcode bit set.
                    n_skip   = i_byte[3] && !i_byte[7];
                    if (!i_byte[7] && i_byte[3:0] != OP_CONT && !i_byte[3]) begin
                        n_frag = i_byte[3:0];
                    end
                    n_phase  = PH_HDR1;
                end
                PH_HDR1: begin
                    n_masked = i_byte[7];
                    if (w_len7 == LEN_EXT16 || w_len7 == LEN_EXT64) begin
                        n_hidx  = (w_len7 == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                        n_phase = PH_EXT;
                    end else begin
                        n_left = {57'd0, w_len7};
                        if (i_byte[7]) begin
                            n_hidx  = KEY_BYTES;
                            n_phase = PH_KEY;
                        end else if (w_len7 == 7'd0) begin
                            w_emit = 1'b1;
                            w_end  = 1'b1;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end
                PH_EXT: begin
                    n_left = {r_left[55:0], i_byte};
                    n_hidx = r_hidx - 4'd1;
                    if (n_hidx == 4'd0) begin
                        if (r_masked) begin
                            n_hidx  = KEY_BYTES;
                            n_phase = PH_KEY;
                        end else if (n_left == 64'd0) begin
                            w_emit = 1'b1;
                            w_end  = 1'b1;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end
                PH_KEY: begin
                    n_key  = {r_key[23:0], i_byte};
                    n_hidx = r_hidx - 4'd1;
                    if (n_hidx == 4'd0) begin
                        if (r_left == 64'd0) begin
                            w_emit = 1'b1;
                            w_end  = 1'b1;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    n_kidx = r_kidx + 2'd1;
                    n_left = r_left - 64'd1;
                    if (r_opcode == OP_TEXT) begin
                        n_utf = w_utf_fed;
                    end
                    if (n_left == 64'd0) begin
                        w_emit = 1'b1;
                        w_end  = 1'b1;
                        w_has  = !r_skip;
                    end else if (!r_skip) begin
                        w_emit = 1'b1;
                        w_has  = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_HDR0;
                end
            endcase

            if (w_end) begin
                n_phase = PH_HDR0;
                if (!n_skip && n_fin && n_opcode == OP_CLOSE) begin
                    n_closed = 1'b1;
                end
            end
        end
    end

    always_comb begin
        o_result.valid        = i_step && w_emit;
        o_result.has_byte     = w_has;
        o_result.data_byte    = w_has ? w_data : 8'd0;
        o_result.msg_opcode   = (n_opcode == OP_CONT) ? n_frag : n_opcode;
        o_result.was_masked   = n_masked;
        o_result.frame_end    = w_end;
        o_result.message_end  = w_end && n_fin;
        if (!w_end) begin
            o_result.frame_status = ST_OK;
        end else if (n_skip) begin
            o_result.frame_status = ST_CTRL;
        end else if (n_opcode == OP_TEXT && (n_utf.bad || n_utf.pending != 2'd0)) begin
            o_result.frame_status = ST_UTF8;
        end else begin
            o_result.frame_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR0;
            r_hidx   <= 4'd0;
            r_fin    <= 1'b0;
            r_opcode <= OP_CONT;
            r_masked <= 1'b0;
            r_left   <= '0;
            r_key    <= '0;
            r_kidx   <= 2'd0;
            r_frag   <= OP_TEXT;
            r_utf    <= '{pending: 2'd0, rule: RULE_NONE, bad: 1'b0};
            r_skip   <= 1'b0;
            r_closed <= 1'b0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_hidx   <= n_hidx;
            r_fin    <= n_fin;
            r_opcode <= n_opcode;
            r_masked <= n_masked;
            r_left   <= n_left;
            r_key    <= n_key;
            r_kidx   <= n_kidx;
            r_frag   <= n_frag;
            r_utf    <= n_utf;
            r_skip   <= n_skip;
            r_closed <= n_closed;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/websocket_frame_decoder_top.sv -----
`default_nettype none

// WebSocket receive-side frame decoder. Feed the received stream one byte per
// transfer on the input channel; the block parses each frame header (FIN,
// opcode, MASK, 7/16/64-bit length, masking key) and returns one result per
// payload byte, unmasked, carrying the message opcode (continuation frames
// report the opcode of the first fragment). A frame with an empty payload
// gives a single result with has_byte low and frame_end high on its last
// header byte. Fragmented control frames produce no payload results and end
// with frame_status 1; TEXT frames are UTF-8 checked and end with status 2 if
// invalid, in which case the consumer should drop the bytes it received for
// that frame. Once an unfragmented CLOSE frame has ended, every later
// byte is swallowed until reset. The block takes one byte per clock
// cycle while the result register is not stalled; a byte is held in the
// input register, is parsed by a single pass of header and UTF-8 logic,
// and its result is captured in the result register. Throughput is
// set only by the output side: the input register stalls when the result
// register is full and not being taken.
module websocket_frame_decoder_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_has_byte,
    output logic [7:0] o_data_byte,
    output logic [3:0] o_msg_opcode,
    output logic       o_was_masked,
    output logic       o_frame_end,
    output logic       o_message_end,
    output logic [1:0] o_frame_status
);
    import wsfd_pkg::*;

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // Result register.
    logic       r_out_valid;
    t_result    r_out;

    logic       w_step;
    t_result    w_result;

    // The parsed byte moves on whenever the result register is free or is
    // being emptied in this cycle.
    assign w_step  = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_step;

    wsfd_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_byte   (r_in_byte),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // A byte that produces no result simply frees the result register if
    // the consumer took the previous one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= w_result.valid;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_result.valid) begin
            r_out <= w_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_has_byte     = r_out.has_byte;
    assign o_data_byte    = r_out.data_byte;
    assign o_msg_opcode   = r_out.msg_opcode;
    assign o_was_masked   = r_out.was_masked;
    assign o_frame_end    = r_out.frame_end;
    assign o_message_end  = r_out.message_end;
    assign o_frame_status = r_out.frame_status;

`ifndef SYNTHESIS
    // A nonzero status is only reported on the last result of a frame.
    a_status_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_status != ST_OK |-> o_frame_end)
        else $error("frame_status set on a result that does not end a frame");

    // A result without a payload byte always closes a frame and carries zero.
    a_empty_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_has_byte |-> o_frame_end && o_data_byte == 8'd0)
        else $error("result without a byte that does not end a frame");

    // A skipped control frame never delivers its payload.
    a_ctrl_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_status == ST_CTRL |-> !o_has_byte)
        else $error("fragmented control frame delivered a payload byte");

    // A stalled result must not be overwritten by the next parsed byte.
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(r_out))
        else $error("pending result changed while stalled");
`endif

endmodule

`default_nettype wire
